// File: src/i2cmw_pkg.sv
// Shared types and constants of the I2C master write engine.
`default_nettype none
package i2cmw_pkg;

	localparam int unsigned TICK_W     = 16;
	localparam int unsigned LIMIT_W    = 8;
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned DATA_W     = 8;
	localparam int unsigned BIT_IDX_W  = 4;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam int unsigned FQ_DEPTH   = 4;
	localparam int unsigned FQ_AW      = $clog2(FQ_DEPTH);
	localparam int unsigned FQ_CW      = $clog2(FQ_DEPTH + 1);
	localparam int unsigned RQ_DEPTH   = 2;
	localparam int unsigned RQ_AW      = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
	localparam int unsigned RQ_CW      = $clog2(RQ_DEPTH + 1);

	localparam logic [BIT_IDX_W-1:0] BYTE_BITS = BIT_IDX_W'(8);

	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BYTE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BIT   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SETUP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd3;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_START = 3'd1,
		KIND_STOP  = 3'd2,
		KIND_BYTE  = 3'd3,
		KIND_BIT   = 3'd4
	} kind_t;

	typedef enum logic [12:0] {
		PH_IDLE      = 13'b0000000000001,
		PH_START_SDA = 13'b0000000000010,
		PH_START_SCL = 13'b0000000000100,
		PH_STOP_SCL  = 13'b0000000001000,
		PH_STOP_SDA  = 13'b0000000010000,
		PH_BIT_HIGH  = 13'b0000000100000,
		PH_BIT_LOW   = 13'b0000001000000,
		PH_BYTE_HIGH = 13'b0000010000000,
		PH_BYTE_LOW  = 13'b0000100000000,
		PH_BYTE_NEXT = 13'b0001000000000,
		PH_ACK_SCL   = 13'b0010000000000,
		PH_ACK_POLL  = 13'b0100000000000,
		PH_END       = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		kind_t              kind;
		logic [DATA_W-1:0]  data;
		logic               sda_in;
	} tick_t;

	typedef struct packed {
		logic [TICK_W-1:0]  setup_ticks;
		logic [TICK_W-1:0]  hold_ticks;
		logic [TICK_W-1:0]  high_ticks;
		logic [LIMIT_W-1:0] ack_retry_limit;
	} cfg_t;

	typedef struct packed {
		logic scl_release;
		logic sda_release;
		logic busy_res;
		logic done_res;
		logic ack_error;
	} res_t;

endpackage
`default_nettype wire

// File: src/i2c_master_write_engine_core.sv
// Top level of the I2C master write engine: configuration registers, front and back ends.
// Every word pushed is one bus timing tick and yields exactly one result word, in order.
// The engine sustains one tick per clock cycle while a tick is queued and the result queue has room:
// the sequencer state advances once per such cycle, and a four-word tick queue in front of it and a
// two-word result queue behind it let either side stall without stopping the other. A tick is registered
// in the tick queue and then its result in the result queue before the result can be popped. Timing
// registers are written through wr_en, wr_index and wr_data and should only change while no sequence is running.
`default_nettype none
module i2c_master_write_engine_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [i2cmw_pkg::CMD_W-1:0]     cmd,
	input  wire logic [i2cmw_pkg::DATA_W-1:0]    data,
	input  wire logic                           sda_in,
	output logic                                empty,
	input  wire logic                           pop,
	output logic                                scl_release,
	output logic                                sda_release,
	output logic                                busy_res,
	output logic                                done_res,
	output logic                                ack_error,
	input  wire logic                           wr_en,
	input  wire logic [i2cmw_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [i2cmw_pkg::TICK_W-1:0]    wr_data
);
	import i2cmw_pkg::*;

	cfg_t  cfg_q;
	tick_t head;
	logic  head_valid;
	logic  head_take;
	res_t  res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_ticks     <= TICK_W'(5);
			cfg_q.hold_ticks      <= TICK_W'(5);
			cfg_q.high_ticks      <= TICK_W'(10);
			cfg_q.ack_retry_limit <= LIMIT_W'(100);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SETUP: cfg_q.setup_ticks     <= wr_data;
				REG_HOLD:  cfg_q.hold_ticks      <= wr_data;
				REG_HIGH:  cfg_q.high_ticks      <= wr_data;
				REG_LIMIT: cfg_q.ack_retry_limit <= wr_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	i2cmw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.data       (data),
		.sda_in     (sda_in),
		.head_valid (head_valid),
		.head       (head),
		.head_take  (head_take)
	);

	i2cmw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.head_take  (head_take),
		.empty      (empty),
		.pop        (pop),
		.res_out    (res_out)
	);

	assign scl_release = res_out.scl_release;
	assign sda_release = res_out.sda_release;
	assign busy_res    = res_out.busy_res;
	assign done_res    = res_out.done_res;
	assign ack_error   = res_out.ack_error;

endmodule
`default_nettype wire

// File: src/i2cmw_front.sv
// Front end: accepts ticks, classifies the command and queues them for the sequencer.
`default_nettype none
module i2cmw_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [i2cmw_pkg::CMD_W-1:0]  cmd,
	input  wire logic [i2cmw_pkg::DATA_W-1:0] data,
	input  wire logic                        sda_in,
	output logic                             head_valid,
	output i2cmw_pkg::tick_t                 head,
	input  wire logic                        head_take
);
	import i2cmw_pkg::*;

	tick_t              mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0]   wr_ptr_q;
	logic [FQ_AW-1:0]   rd_ptr_q;
	logic [FQ_CW-1:0]   count_q;
	tick_t              entry;
	logic               wr_fire;
	logic               rd_fire;

	// A single bit is carried in the MSB so the sequencer treats it like a byte's first bit.
	always_comb begin
		entry.data   = data;
		entry.sda_in = sda_in;
		unique case (cmd)
			CMD_START: entry.kind = KIND_START;
			CMD_STOP:  entry.kind = KIND_STOP;
			CMD_BYTE:  entry.kind = KIND_BYTE;
			CMD_BIT: begin
				entry.kind = KIND_BIT;
				entry.data = {(data != '0), {(DATA_W-1){1'b0}}};
			end
			default:   entry.kind = KIND_NONE;
		endcase
	end

	assign full       = (count_q == FQ_CW'(FQ_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign wr_fire    = push && !full;
	assign rd_fire    = head_take && head_valid;

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + FQ_AW'(1);
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + FQ_AW'(1);
			end
			if (wr_fire && !rd_fire) begin
				count_q <= count_q + FQ_CW'(1);
			end else if (rd_fire && !wr_fire) begin
				count_q <= count_q - FQ_CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: src/i2cmw_back.sv
// Back end: the line sequencer, one tick per step, with its result queue.
`default_nettype none
module i2cmw_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire i2cmw_pkg::cfg_t  cfg,
	input  wire logic             head_valid,
	input  wire i2cmw_pkg::tick_t head,
	output logic                  head_take,
	output logic                  empty,
	input  wire logic             pop,
	output i2cmw_pkg::res_t       res_out
);
	import i2cmw_pkg::*;

	phase_t                 phase_q, phase_n;
	logic [TICK_W-1:0]      wait_q, wait_n;
	logic [BIT_IDX_W-1:0]   bit_q, bit_n;
	logic [DATA_W-1:0]      shift_q, shift_n;
	logic [LIMIT_W-1:0]     retry_q, retry_n;
	logic                   scl_q, scl_n;
	logic                   sda_q, sda_n;
	logic                   err_q, err_n;
	logic [LIMIT_W:0]       retry_inc;
	logic [BIT_IDX_W-1:0]   bit_inc;
	logic [DATA_W-1:0]      shift_inc;
	res_t                   res;

	res_t                   rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0]       rq_wr_q;
	logic [RQ_AW-1:0]       rq_rd_q;
	logic [RQ_CW-1:0]       rq_cnt_q;
	logic                   step;
	logic                   rq_pop;

	assign step      = head_valid && (rq_cnt_q != RQ_CW'(RQ_DEPTH));
	assign head_take = step;
	assign retry_inc = {1'b0, retry_q} + (LIMIT_W+1)'(1);
	assign bit_inc   = bit_q + BIT_IDX_W'(1);
	assign shift_inc = {shift_q[DATA_W-2:0], 1'b0};

	always_comb begin
		phase_n = phase_q;
		wait_n  = wait_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		retry_n = retry_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		err_n   = err_q;
		res     = '0;
		if (phase_q == PH_IDLE) begin
			if (head.kind != KIND_NONE) begin
				err_n        = 1'b0;
				retry_n      = '0;
				res.busy_res = 1'b1;
				wait_n       = cfg.setup_ticks;
				unique case (head.kind)
					KIND_START: begin
						scl_n   = 1'b1;
						sda_n   = 1'b1;
						phase_n = PH_START_SDA;
					end
					KIND_STOP: begin
						sda_n   = 1'b0;
						phase_n = PH_STOP_SCL;
					end
					KIND_BYTE: begin
						shift_n = head.data;
						bit_n   = '0;
						sda_n   = head.data[DATA_W-1];
						phase_n = PH_BYTE_HIGH;
					end
					KIND_BIT: begin
						sda_n   = head.data[DATA_W-1];
						phase_n = PH_BIT_HIGH;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end else if (wait_q != '0) begin
			wait_n       = wait_q - TICK_W'(1);
			res.busy_res = 1'b1;
		end else begin
			res.busy_res = 1'b1;
			unique case (phase_q)
				PH_START_SDA: begin
					sda_n = 1'b0; wait_n = cfg.hold_ticks; phase_n = PH_START_SCL;
				end
				PH_START_SCL: begin
					scl_n = 1'b0; wait_n = cfg.high_ticks; phase_n = PH_END;
				end
				PH_STOP_SCL: begin
					scl_n = 1'b1; wait_n = cfg.high_ticks; phase_n = PH_STOP_SDA;
				end
				PH_STOP_SDA: begin
					sda_n = 1'b1; wait_n = cfg.high_ticks; phase_n = PH_END;
				end
				PH_BIT_HIGH: begin
					scl_n = 1'b1; wait_n = cfg.high_ticks; phase_n = PH_BIT_LOW;
				end
				PH_BIT_LOW: begin
					scl_n = 1'b0; wait_n = cfg.hold_ticks; phase_n = PH_END;
				end
				PH_BYTE_HIGH: begin
					scl_n = 1'b1; wait_n = cfg.high_ticks; phase_n = PH_BYTE_LOW;
				end
				PH_BYTE_LOW: begin
					scl_n = 1'b0; wait_n = cfg.hold_ticks; phase_n = PH_BYTE_NEXT;
				end
				PH_BYTE_NEXT: begin
					shift_n = shift_inc;
					bit_n   = bit_inc;
					wait_n  = cfg.setup_ticks;
					if (bit_inc < BYTE_BITS) begin
						sda_n   = shift_inc[DATA_W-1];
						phase_n = PH_BYTE_HIGH;
					end else begin
						sda_n   = 1'b1;
						phase_n = PH_ACK_SCL;
					end
				end
				PH_ACK_SCL: begin
					scl_n = 1'b1; wait_n = cfg.hold_ticks; phase_n = PH_ACK_POLL;
				end
				PH_ACK_POLL: begin
					wait_n = cfg.setup_ticks;
					if (!head.sda_in) begin
						scl_n   = 1'b0;
						wait_n  = cfg.hold_ticks;
						phase_n = PH_END;
					end else if (retry_inc > {1'b0, cfg.ack_retry_limit}) begin
						err_n   = 1'b1;
						sda_n   = 1'b0;
						phase_n = PH_STOP_SCL;
					end else begin
						retry_n = retry_inc[LIMIT_W-1:0];
						phase_n = PH_ACK_POLL;
					end
				end
				default: begin
					phase_n       = PH_IDLE;
					wait_n        = '0;
					res.busy_res  = 1'b0;
					res.done_res  = 1'b1;
					res.ack_error = err_q;
				end
			endcase
		end
		res.scl_release = scl_n;
		res.sda_release = sda_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			retry_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			wait_q  <= wait_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			retry_q <= retry_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			err_q   <= err_n;
		end
	end

	assign empty   = (rq_cnt_q == '0);
	assign rq_pop  = pop && !empty;
	assign res_out = rq_q[rq_rd_q];

	always_ff @(posedge clk) begin
		if (step) begin
			rq_q[rq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (step) begin
				rq_wr_q <= (rq_wr_q == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_wr_q + RQ_AW'(1);
			end
			if (rq_pop) begin
				rq_rd_q <= (rq_rd_q == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_rd_q + RQ_AW'(1);
			end
			if (step && !rq_pop) begin
				rq_cnt_q <= rq_cnt_q + RQ_CW'(1);
			end else if (rq_pop && !step) begin
				rq_cnt_q <= rq_cnt_q - RQ_CW'(1);
			end
		end
	end

	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.ack_error |-> res.done_res)
		else $error("ack error reported without done");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |-> !res.busy_res)
		else $error("done and busy reported together");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |=> phase_q == PH_IDLE)
		else $error("sequencer not idle after done");

	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= RQ_CW'(RQ_DEPTH))
		else $error("result queue overflow");

endmodule
`default_nettype wire
